@@ rtl/lxm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxm_pkg
// Shared types and constants of the L128X1024 LXM random generator.
// ----------------------------------------------------------------------------
package lxm_pkg;

  // data and lattice geometry
  localparam int WORD_W        = 64;
  localparam int HALF_W        = WORD_W / 2;
  localparam int LATTICE_WORDS = 16;
  localparam int LAT_IDX_W     = $clog2(LATTICE_WORDS);

  // xoroshiro1024 rotate and shift amounts
  localparam int ROT_A   = 25;
  localparam int SHIFT_B = 27;
  localparam int ROT_C   = 36;

  // mixer multiplier and register reset values
  localparam logic [WORD_W-1:0] LEA_MULT       = 64'hdaba0b6eb09322e3;
  localparam logic [WORD_W-1:0] MULT_LOW_RESET = 64'hd605bbb58c8abbfd;
  localparam logic [WORD_W-1:0] ADD_HIGH_RESET = 64'h0;
  localparam logic [WORD_W-1:0] ADD_LOW_RESET  = 64'h1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDEND_HIGH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDEND_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER_LOW = 2'd2;

  // commands
  typedef enum logic [1:0] {
    CMD_GENERATE  = 2'd0,
    CMD_LOAD_WORD = 2'd1,
    CMD_LOAD_HIGH = 2'd2,
    CMD_LOAD_LOW  = 2'd3
  } cmd_t;

  // one queued request, classified by the front part
  typedef struct packed {
    logic                 is_gen;
    cmd_t                 cmd;
    logic [LAT_IDX_W-1:0] word_index;
    logic [WORD_W-1:0]    load_value;
  } op_t;

endpackage

@@ rtl/lxm_item_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxm_item_if
// Request channel: command, lattice word index and load value.
// ----------------------------------------------------------------------------
interface lxm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  word_index;
  logic [63:0] load_value;

  modport source (output valid, output cmd, output word_index, output load_value,
                  input ready);
  modport sink   (input valid, input cmd, input word_index, input load_value,
                  output ready);
endinterface

@@ rtl/lxm_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxm_result_if
// Result channel: one 64-bit random word per request.
// ----------------------------------------------------------------------------
interface lxm_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

@@ rtl/lxm_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lxm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/lxm_l128x1024_random_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxm_l128x1024_random_generator
// LXM generator: 128-bit LCG combined with a xoroshiro1024 lattice, Lea mixer.
// ----------------------------------------------------------------------------
// Usage:
//   item   - request channel (cmd, word_index, load_value). A generate request
//            returns the next random word; load requests write one lattice word
//            or one LCG half and return zero.
//   result - one random_word per request, in request order.
//   cfg    - register writes (addend high, addend low, multiplier low); always
//            ready, to be used only while no request is outstanding.
// Execution:
//   A generate request steps through states G1 to G6 in the execution unit:
//   one shared two-stage 64x64 multiplier is used in turn for the LCG low and
//   high products and the two mixer rounds. A load request is executed when
//   it is popped and writes a zero into the result register.
// Reset: rst is synchronous; it clears the lattice, sets lcg_high to zero,
//   lcg_low to one and the registers to their defaults.
// Stalls: a two-entry queue keeps accepting requests while a result waits in
//   the output register; execution pauses until the result is taken.
// ----------------------------------------------------------------------------
module lxm_l128x1024_random_generator
  import lxm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  lxm_item_if.sink     item,
  lxm_cfg_if.sink      cfg,
  lxm_result_if.source result
);

  logic head_valid;
  op_t  head;
  logic pop;

  lxm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  lxm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg        (cfg),
    .result     (result)
  );

endmodule

@@ rtl/lxm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxm_front
// Accepts requests, classifies the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lxm_front
  import lxm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lxm_item_if.sink    item,
  output logic        head_valid,
  output op_t         head,
  input  logic        pop
);

  localparam int DEPTH = 2;

  op_t        queue [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  op_t        incoming;

  // classify the incoming request
  always_comb begin
    incoming.cmd        = cmd_t'(item.cmd);
    incoming.is_gen     = (cmd_t'(item.cmd) == CMD_GENERATE);
    incoming.word_index = item.word_index;
    incoming.load_value = item.load_value;
  end

  assign item.ready = (count != 2'(DEPTH));
  assign push       = item.valid && item.ready;
  assign head_valid = (count != 2'd0);
  assign head       = queue[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/lxm_mul64.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxm_mul64
// Two-stage 64x64 to 128-bit multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module lxm_mul64
  import lxm_pkg::*;
(
  input  logic                  clk,
  input  logic                  hold,
  input  logic [WORD_W-1:0]     a,
  input  logic [WORD_W-1:0]     b,
  output logic [2*WORD_W-1:0]   prod
);

  logic [WORD_W-1:0] pp_ll;
  logic [WORD_W-1:0] pp_lh;
  logic [WORD_W-1:0] pp_hl;
  logic [WORD_W-1:0] pp_hh;
  logic [HALF_W+1:0] mid;
  logic [WORD_W-1:0] high;

  // first stage: partial products
  always_ff @(posedge clk) begin
    if (!hold) begin
      pp_ll <= a[HALF_W-1:0]      * b[HALF_W-1:0];
      pp_lh <= a[HALF_W-1:0]      * b[WORD_W-1:HALF_W];
      pp_hl <= a[WORD_W-1:HALF_W] * b[HALF_W-1:0];
      pp_hh <= a[WORD_W-1:HALF_W] * b[WORD_W-1:HALF_W];
    end
  end

  // column sums of the middle and upper words
  always_comb begin
    mid  = (HALF_W+2)'(pp_ll[WORD_W-1:HALF_W]) + (HALF_W+2)'(pp_lh[HALF_W-1:0])
         + (HALF_W+2)'(pp_hl[HALF_W-1:0]);
    high = pp_hh + WORD_W'(pp_lh[WORD_W-1:HALF_W]) + WORD_W'(pp_hl[WORD_W-1:HALF_W])
         + WORD_W'(mid[HALF_W+1:HALF_W]);
  end

  // second stage: full product
  always_ff @(posedge clk) begin
    if (!hold) begin
      prod <= {high, mid[HALF_W-1:0], pp_ll[HALF_W-1:0]};
    end
  end

endmodule

@@ rtl/lxm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxm_back
// Executes queued requests: lattice and LCG state, sequencing of the shared
// multiplier for the LCG step and the mixer, and the result register.
// ----------------------------------------------------------------------------
module lxm_back
  import lxm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  op_t         head,
  output logic        pop,
  lxm_cfg_if.sink     cfg,
  lxm_result_if.source result
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_G1   = 7'b0000010,
    ST_G2   = 7'b0000100,
    ST_G3   = 7'b0001000,
    ST_G4   = 7'b0010000,
    ST_G5   = 7'b0100000,
    ST_G6   = 7'b1000000
  } state_t;

  state_t               state;
  logic [WORD_W-1:0]    addend_high;
  logic [WORD_W-1:0]    addend_low;
  logic [WORD_W-1:0]    multiplier_low;
  logic [WORD_W-1:0]    lcg_high;
  logic [WORD_W-1:0]    lcg_low;
  logic [LAT_IDX_W-1:0] position;
  logic [WORD_W-1:0]    lattice [LATTICE_WORDS];
  logic [WORD_W-1:0]    mix_in;
  logic [WORD_W-1:0]    new_low;
  logic                 low_carry;
  logic [WORD_W-1:0]    high_part;
  logic                 out_valid;
  logic [WORD_W-1:0]    out_data;

  logic                 slot_free;
  logic                 hold;
  logic [WORD_W-1:0]    mul_a;
  logic [WORD_W-1:0]    mul_b;
  logic [2*WORD_W-1:0]  prod;
  logic [WORD_W-1:0]    z_sum;
  logic [WORD_W-1:0]    s15x;
  logic [WORD_W-1:0]    lat_a;
  logic [WORD_W-1:0]    lat_b;
  logic [WORD_W-1:0]    mix_mid;
  logic [WORD_W:0]      low_sum;
  logic [LAT_IDX_W-1:0] slot_idx;

  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.random_word = out_data;

  assign slot_free = !out_valid || result.ready;
  assign hold      = (state == ST_G6) && !slot_free;
  assign pop       = (state == ST_IDLE) && head_valid && (head.is_gen || slot_free);

  // lattice is kept rotated: entry 0 is the current word, entry 1 the next
  always_comb begin
    z_sum    = lcg_high + lattice[1];
    s15x     = lattice[0] ^ lattice[1];
    lat_a    = {lattice[1][WORD_W-ROT_A-1:0], lattice[1][WORD_W-1:WORD_W-ROT_A]}
             ^ s15x ^ (s15x << SHIFT_B);
    lat_b    = {s15x[WORD_W-ROT_C-1:0], s15x[WORD_W-1:WORD_W-ROT_C]};
    slot_idx = head.word_index - position;
    mix_mid  = prod[WORD_W-1:0] ^ (prod[WORD_W-1:0] >> HALF_W);
    low_sum  = {1'b0, prod[WORD_W-1:0]} + {1'b0, addend_low};
  end

  // shared multiplier operand selection
  always_comb begin
    case (state)
      ST_IDLE: begin
        mul_a = multiplier_low;
        mul_b = lcg_low;
      end
      ST_G1: begin
        mul_a = multiplier_low;
        mul_b = lcg_high;
      end
      ST_G2: begin
        mul_a = mix_in;
        mul_b = LEA_MULT;
      end
      ST_G4: begin
        mul_a = mix_mid;
        mul_b = LEA_MULT;
      end
      default: begin
        mul_a = mix_in;
        mul_b = LEA_MULT;
      end
    endcase
  end

  lxm_mul64 u_mul (
    .clk  (clk),
    .hold (hold),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      addend_high    <= ADD_HIGH_RESET;
      addend_low     <= ADD_LOW_RESET;
      multiplier_low <= MULT_LOW_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ADDEND_HIGH:    addend_high    <= cfg.data;
        CFG_ADDEND_LOW:     addend_low     <= cfg.data | ADD_LOW_RESET;
        CFG_MULTIPLIER_LOW: multiplier_low <= cfg.data;
        default:            addend_high    <= addend_high;
      endcase
    end
  end

  // intermediate terms of the lcg and mixer
  always_ff @(posedge clk) begin
    if (pop && head.is_gen) begin
      mix_in <= z_sum ^ (z_sum >> HALF_W);
    end
    if (state == ST_G2) begin
      new_low   <= low_sum[WORD_W-1:0];
      low_carry <= low_sum[WORD_W];
      high_part <= prod[2*WORD_W-1:WORD_W] + lcg_low + addend_high;
    end
  end

  // sequencer, generator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lcg_high  <= '0;
      lcg_low   <= WORD_W'(1);
      position  <= '0;
      out_valid <= 1'b0;
      out_data  <= '0;
      for (int i = 0; i < LATTICE_WORDS; i++) begin
        lattice[i] <= '0;
      end
    end else begin
      // a new word fills the slot, otherwise a taken word empties it
      if ((pop && !head.is_gen) || ((state == ST_G6) && slot_free)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (head.is_gen) begin
              lattice[0] <= lat_b;
              for (int i = 1; i < LATTICE_WORDS - 1; i++) begin
                lattice[i] <= lattice[i+1];
              end
              lattice[LATTICE_WORDS-1] <= lat_a;
              position <= position + LAT_IDX_W'(1);
              state    <= ST_G1;
            end else begin
              case (head.cmd)
                CMD_LOAD_WORD: lattice[slot_idx] <= head.load_value;
                CMD_LOAD_HIGH: lcg_high <= head.load_value;
                CMD_LOAD_LOW:  lcg_low  <= head.load_value;
                default:       lcg_low  <= lcg_low;
              endcase
              out_data <= '0;
            end
          end
        end
        ST_G1: state <= ST_G2;
        ST_G2: state <= ST_G3;
        ST_G3: begin
          lcg_high <= prod[WORD_W-1:0] + high_part + WORD_W'(low_carry);
          lcg_low  <= new_low;
          state    <= ST_G4;
        end
        ST_G4: state <= ST_G5;
        ST_G5: state <= ST_G6;
        ST_G6: begin
          if (slot_free) begin
            out_data <= prod[WORD_W-1:0] ^ (prod[WORD_W-1:0] >> HALF_W);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_lxm_l128x1024_random_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lxm_l128x1024_random_generator
// Self-checking bench for the LXM L128X1024 generator. A cycle-free model of
// the LCG, the xoroshiro1024 lattice and the Lea mixer predicts one word per
// accepted request, and every returned word is checked in order. The run has
// a directed opening and then several register settings, each with random
// generate and load requests and, but for the last, random idle bursts on
// both channels; one long result hold-off follows the first setting.
// ----------------------------------------------------------------------------
module tb_lxm_l128x1024_random_generator;
  import lxm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int GEN_LATENCY = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 360;

  // predicts the word returned for each request and keeps them in order
  class random_word_tracker;
    logic [WORD_W-1:0]    addend_high;
    logic [WORD_W-1:0]    addend_low;
    logic [WORD_W-1:0]    multiplier_low;
    logic [WORD_W-1:0]    lattice [LATTICE_WORDS];
    logic [WORD_W-1:0]    lcg_high;
    logic [WORD_W-1:0]    lcg_low;
    logic [LAT_IDX_W-1:0] position;
    logic [WORD_W-1:0]    expected_words [$];
    int                   errors;

    function new();
      addend_high    = ADD_HIGH_RESET;
      addend_low     = ADD_LOW_RESET;
      multiplier_low = MULT_LOW_RESET;
      foreach (lattice[i]) lattice[i] = '0;
      lcg_high = '0;
      lcg_low  = 64'd1;
      position = '0;
      errors   = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [WORD_W-1:0] data);
      case (index)
        CFG_ADDEND_HIGH:    addend_high    = data;
        CFG_ADDEND_LOW:     addend_low     = data | 64'd1;
        CFG_MULTIPLIER_LOW: multiplier_low = data;
        default: ;
      endcase
    endfunction

    function void note_request(cmd_t cmd, logic [LAT_IDX_W-1:0] index,
                               logic [WORD_W-1:0] value);
      logic [LAT_IDX_W-1:0] nxt;
      logic [WORD_W-1:0]    s0;
      logic [WORD_W-1:0]    s15;
      logic [WORD_W-1:0]    mixed;
      logic [2*WORD_W-1:0]  lcg;
      mixed = '0;
      case (cmd)
        CMD_GENERATE: begin
          nxt = position + 1'b1;
          s0  = lattice[nxt];
          s15 = lattice[position];
          // two xor-shift-multiply rounds and a final fold
          mixed = lcg_high + s0;
          repeat (2) mixed = (mixed ^ (mixed >> HALF_W)) * LEA_MULT;
          mixed = mixed ^ (mixed >> HALF_W);
          // 128-bit lcg, multiplier has an implied one in the high half
          lcg = {lcg_high, lcg_low} * {64'd1, multiplier_low} + {addend_high, addend_low};
          {lcg_high, lcg_low} = lcg;
          // xoroshiro1024 step on the two active words
          s15 = s15 ^ s0;
          lattice[position] = ((s0 << ROT_A) | (s0 >> (WORD_W - ROT_A)))
                              ^ s15 ^ (s15 << SHIFT_B);
          lattice[nxt] = (s15 << ROT_C) | (s15 >> (WORD_W - ROT_C));
          position = nxt;
        end
        CMD_LOAD_WORD: lattice[index] = value;
        CMD_LOAD_HIGH: lcg_high = value;
        default:       lcg_low = value;
      endcase
      expected_words.push_back(mixed);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_word(logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected random_word %h", word));
      end else begin
        want = expected_words.pop_front();
        if (word !== want)
          report($sformatf("random_word %h, expected %h", word, want));
      end
    endtask

    function int outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lxm_item_if   item_bus ();
  lxm_cfg_if    cfg_bus ();
  lxm_result_if result_bus ();

  lxm_l128x1024_random_generator dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .cfg    (cfg_bus),
    .result (result_bus)
  );

  random_word_tracker tracker;
  bit idle_bursts  = 1'b1;
  bit hold_results = 1'b0;
  int stall_count  = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // observe every handshake at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) tracker.check_word(result_bus.random_word);
      if (cfg_bus.valid && cfg_bus.ready) tracker.write_register(cfg_bus.index, cfg_bus.data);
      if (item_bus.valid && item_bus.ready)
        tracker.note_request(cmd_t'(item_bus.cmd), item_bus.word_index, item_bus.load_value);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("tb_lxm_l128x1024_random_generator NOT OK");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    result_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if (idle_bursts && $urandom_range(0, 4) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        result_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one request and return at the edge where it is taken
  task automatic send_request(cmd_t cmd, logic [LAT_IDX_W-1:0] index,
                              logic [WORD_W-1:0] value, bit may_idle = 1'b1);
    if (may_idle && idle_bursts && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.cmd        <= cmd;
    item_bus.word_index <= index;
    item_bus.load_value <= value;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
  endtask

  task automatic send_random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      send_request(CMD_GENERATE, LAT_IDX_W'($urandom_range(0, 15)), {$urandom, $urandom});
    else if (pick < 88)
      send_request(CMD_LOAD_WORD, LAT_IDX_W'($urandom_range(0, 15)), pick_word());
    else if (pick < 94)
      send_request(CMD_LOAD_HIGH, LAT_IDX_W'($urandom_range(0, 15)), pick_word());
    else
      send_request(CMD_LOAD_LOW, LAT_IDX_W'($urandom_range(0, 15)), pick_word());
  endtask

  // stop offering and wait for every outstanding word
  task automatic drain();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (GEN_LATENCY) @(posedge clk);
  endtask

  task automatic program_registers(logic [WORD_W-1:0] add_high, logic [WORD_W-1:0] add_low,
                                   logic [WORD_W-1:0] mult_low);
    logic [CFG_IDX_W-1:0] indexes [4];
    logic [WORD_W-1:0]    values [4];
    indexes = '{CFG_ADDEND_HIGH, CFG_ADDEND_LOW, CFG_MULTIPLIER_LOW, CFG_UNUSED};
    values  = '{add_high, add_low, mult_low, pick_word()};
    foreach (indexes[i]) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= indexes[i];
      cfg_bus.data  <= values[i];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // one register setting: reseed the whole lattice, then random traffic
  task automatic run_phase(logic [WORD_W-1:0] add_high, logic [WORD_W-1:0] add_low,
                           logic [WORD_W-1:0] mult_low);
    drain();
    program_registers(add_high, add_low, mult_low);
    for (int w = 0; w < LATTICE_WORDS; w++)
      send_request(CMD_LOAD_WORD, LAT_IDX_W'(w), {$urandom, $urandom} | 64'd1);
    repeat (PHASE_ITEMS) send_random_request();
  endtask

  initial begin
    tracker = new();
    rst                 <= 1'b1;
    item_bus.valid      <= 1'b0;
    item_bus.cmd        <= CMD_GENERATE;
    item_bus.word_index <= '0;
    item_bus.load_value <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_ADDEND_HIGH;
    cfg_bus.data        <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // lattice still all zero: output is the mixed lcg high word
    send_request(CMD_GENERATE, 4'hf, '1);
    send_request(CMD_GENERATE, 4'h0, '0);
    // lattice extremes
    send_request(CMD_LOAD_WORD, 4'h0, '1);
    send_request(CMD_LOAD_WORD, 4'hf, 64'h8000_0000_0000_0001);
    send_request(CMD_LOAD_WORD, 4'h1, {$urandom, $urandom});
    send_request(CMD_LOAD_WORD, 4'h8, '0);
    // full lcg state, carry out of the low half
    send_request(CMD_LOAD_HIGH, 4'h5, '1);
    send_request(CMD_LOAD_LOW, 4'ha, '1);
    repeat (3) send_request(CMD_GENERATE, LAT_IDX_W'($urandom_range(0, 15)),
                            {$urandom, $urandom});
    // even lcg low is taken as it is
    send_request(CMD_LOAD_LOW, 4'h3, 64'hffff_ffff_ffff_fffe);
    repeat (2) send_request(CMD_GENERATE, 4'hf, '1);
    send_request(CMD_LOAD_HIGH, 4'h0, '0);
    send_request(CMD_LOAD_LOW, 4'hf, '0);
    repeat (2) send_request(CMD_GENERATE, 4'h0, '0);

    run_phase('1, '1, '1);
    // hold results back while requests keep coming
    hold_results = 1'b1;
    repeat (12) send_request(CMD_GENERATE, LAT_IDX_W'($urandom_range(0, 15)),
                             {$urandom, $urandom}, 1'b0);
    run_phase('0, '0, '0);
    drain();
    run_phase({$urandom, $urandom}, {$urandom, $urandom} & ~64'd1, {$urandom, $urandom});
    run_phase(ADD_HIGH_RESET, ADD_LOW_RESET, MULT_LOW_RESET);
    // final stretch without idle bursts
    idle_bursts = 1'b0;
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    drain();

    if (tracker.errors == 0) begin
      $display("tb_lxm_l128x1024_random_generator OK");
    end else begin
      $display("tb_lxm_l128x1024_random_generator NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lxm_pkg.sv
rtl/lxm_item_if.sv
rtl/lxm_result_if.sv
rtl/lxm_cfg_if.sv
rtl/lxm_front.sv
rtl/lxm_mul64.sv
rtl/lxm_back.sv
rtl/lxm_l128x1024_random_generator.sv
dv/tb_lxm_l128x1024_random_generator.sv
